[rtl/tpps_pkg.sv]
// Package for the two-axis PID pointer step core.
// Holds widths, register indexes, opcodes, state codes and the config struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpps_pkg;

    localparam int COORD_W    = 20;
    localparam int STEP_W     = 20;
    localparam int GAIN_W     = 32;
    localparam int SCALE_W    = 24;
    localparam int MOVE_W     = 16;
    localparam int ERR_W      = 21;
    localparam int DIFF_W     = 22;
    localparam int INTEG_W    = 48;
    localparam int CARRY_W    = 24;
    localparam int FRAC_BITS  = 23;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int DIVD_W     = 52;
    localparam int DRV_W      = 64;
    localparam int MAG_W      = 63;
    localparam int ACC_W      = 41;
    localparam int TOT_W      = 43;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROP     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_STEP = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE    = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0]        center;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic [STEP_W-1:0]         min_step;
        logic [SCALE_W-1:0]        scale;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_EDT  = 3'd0,
        OP_KP   = 3'd1,
        OP_KILO = 3'd2,
        OP_KIHI = 3'd3,
        OP_KD   = 3'd4,
        OP_SLO  = 3'd5,
        OP_SHI  = 3'd6
    } op_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_ACC   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_ABS   = 7'b0010000,
        ST_CARRY = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    function automatic logic [GAIN_W-1:0] mag32(input logic [GAIN_W-1:0] v);
        mag32 = v[GAIN_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage
`default_nettype wire

[rtl/two_axis_pid_pointer_step_core.sv]
// Two-axis PID pointer step: one input word gives one move word after a
// sequenced pass per axis through a shared multiplier and a serial divider.
// Depends on tpps_pkg, tpps_cfg, tpps_mul and tpps_div.
`timescale 1ns / 1ps
`default_nettype none
// Per input word, each axis runs seven multiplies on the one shared 32x32
// multiplier, the derivative divide, and sign, abs and carry handling.
// s_tready is high only while the core is idle; a finished move word waits
// in the output register while the next input word is accepted.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while the core is idle, as the block does not enforce this.
module two_axis_pid_pointer_step_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [tpps_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tpps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // target_x [19:0], target_y [39:20], elapsed_us [59:40], zero pad
    input  wire logic [tpps_pkg::S_DATA_W-1:0]   s_tdata,
    // restart [0]
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // move_x [15:0], move_y [31:16]
    output logic      [tpps_pkg::M_DATA_W-1:0]   m_tdata
);
    import tpps_pkg::*;

    cfg_t cfg;

    tpps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    state_t state_reg;
    op_t    op_reg;
    logic   axis_reg;

    logic [COORD_W-1:0]       tgt_x_reg, tgt_y_reg;
    logic [STEP_W-1:0]        dt_reg;
    logic [INTEG_W-1:0]       integ_x_reg, integ_y_reg;
    logic [ERR_W-1:0]         last_x_reg, last_y_reg;
    logic [CARRY_W-1:0]       carry_x_reg, carry_y_reg;
    logic [DRV_W-1:0]         drv_reg;
    logic [PROD_W-1:0]        part_reg;
    logic [MAG_W-1:0]         md_reg;
    logic [ACC_W-1:0]         ma_reg;
    logic                     ma_neg_reg;
    logic                     kd_neg_reg;
    logic [MOVE_W-1:0]        move_x_reg, move_y_reg;
    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;

    logic                     in_fire;
    logic [STEP_W-1:0]        in_dt, dt_clamp;

    logic [COORD_W-1:0]       tgt_cur;
    logic [INTEG_W-1:0]       integ_cur;
    logic [ERR_W-1:0]         last_cur;
    logic [CARRY_W-1:0]       carry_cur;
    logic [ERR_W-1:0]         e_cur;
    logic                     e_neg;
    logic [ERR_W-1:0]         e_abs;
    logic [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [INTEG_W-1:0]       integ_abs;
    logic [GAIN_W-1:0]        kp_mag, ki_mag, kd_mag;

    logic                     mul_en;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        prod;

    logic                     div_start;
    logic                     div_busy;
    logic [DIVD_W-1:0]        quot;

    logic signed [INTEG_W+1:0] edt_s, isum;
    logic [INTEG_W-1:0]       isat;
    logic [DRV_W-1:0]         pm, tm;
    logic [87:0]              tsum;
    logic [61:0]              t_mag;
    logic [DRV_W-1:0]         qm;
    logic [95:0]              stot;
    logic [78:0]              sh;
    logic [ACC_W-1:0]         ma_cap;
    logic [TOT_W-1:0]         ma_ext, tot, tot_mag;
    logic [STEP_W-1:0]        m_mag;
    logic [CARRY_W-1:0]       carry_new;
    logic [MOVE_W-1:0]        move_new;
    logic                     out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_dt    = s_tdata[59:40];
    assign dt_clamp = (in_dt < cfg.min_step) ? cfg.min_step : in_dt;

    assign tgt_cur   = axis_reg ? tgt_y_reg   : tgt_x_reg;
    assign integ_cur = axis_reg ? integ_y_reg : integ_x_reg;
    assign last_cur  = axis_reg ? last_y_reg  : last_x_reg;
    assign carry_cur = axis_reg ? carry_y_reg : carry_x_reg;

    assign e_cur     = {1'b0, tgt_cur} - {1'b0, cfg.center};
    assign e_neg     = e_cur[ERR_W-1];
    assign e_abs     = e_neg ? (~e_cur + 1'b1) : e_cur;
    assign diff      = {e_cur[ERR_W-1], e_cur} - {last_cur[ERR_W-1], last_cur};
    assign diff_abs  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign integ_abs = integ_cur[INTEG_W-1] ? (~integ_cur + 1'b1) : integ_cur;
    assign kp_mag    = mag32(cfg.kp);
    assign ki_mag    = mag32(cfg.ki);
    assign kd_mag    = mag32(cfg.kd);

    always_comb begin
        case (op_reg)
            OP_EDT:  begin mul_a = MUL_W'(e_abs);  mul_b = MUL_W'(dt_reg);                 end
            OP_KP:   begin mul_a = kp_mag;         mul_b = MUL_W'(e_abs);                  end
            OP_KILO: begin mul_a = ki_mag;         mul_b = MUL_W'(integ_abs[23:0]);        end
            OP_KIHI: begin mul_a = ki_mag;         mul_b = MUL_W'(integ_abs[47:24]);       end
            OP_KD:   begin mul_a = kd_mag;         mul_b = MUL_W'(diff_abs);               end
            OP_SLO:  begin mul_a = md_reg[31:0];   mul_b = MUL_W'(cfg.scale);              end
            OP_SHI:  begin mul_a = MUL_W'(md_reg[MAG_W-1:32]); mul_b = MUL_W'(cfg.scale);  end
            default: begin mul_a = '0;             mul_b = '0;                             end
        endcase
    end

    assign mul_en = (state_reg == ST_MUL);

    tpps_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign div_start = (state_reg == ST_ACC) && (op_reg == OP_KD);

    tpps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod[DIVD_W-1:0]),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb begin
        edt_s = $signed({10'b0, prod[39:0]});
        if (e_neg) begin
            edt_s = -edt_s;
        end
        isum = $signed({{2{integ_cur[INTEG_W-1]}}, integ_cur}) + edt_s;
        if (isum[INTEG_W+1:INTEG_W-1] == 3'b000 || isum[INTEG_W+1:INTEG_W-1] == 3'b111) begin
            isat = isum[INTEG_W-1:0];
        end else begin
            isat = {isum[INTEG_W+1], {(INTEG_W-1){!isum[INTEG_W+1]}}};
        end

        pm = {12'b0, prod[51:0]};
        if (e_neg ^ cfg.kp[GAIN_W-1]) begin
            pm = ~pm + 1'b1;
        end

        tsum = {24'b0, part_reg} + {prod, 24'b0};
        if ((|tsum[87:62]) || (tsum[61] && (|tsum[60:0]))) begin
            t_mag = {1'b1, 61'b0};
        end else begin
            t_mag = tsum[61:0];
        end
        tm = {2'b0, t_mag};
        if (cfg.ki[GAIN_W-1] ^ integ_cur[INTEG_W-1]) begin
            tm = ~tm + 1'b1;
        end

        qm = {12'b0, quot};
        if (kd_neg_reg) begin
            qm = ~qm + 1'b1;
        end

        stot = {32'b0, part_reg} + {prod, 32'b0};
        sh   = stot[95:17];
        if ((|sh[78:41]) || (sh[40] && (|sh[39:0]))) begin
            ma_cap = {1'b1, 40'b0};
        end else begin
            ma_cap = sh[40:0];
        end

        ma_ext = {2'b0, ma_reg};
        if (ma_neg_reg) begin
            ma_ext = ~ma_ext + 1'b1;
        end
        tot     = ma_ext + {{(TOT_W-CARRY_W){carry_cur[CARRY_W-1]}}, carry_cur};
        tot_mag = tot[TOT_W-1] ? (~tot + 1'b1) : tot;
        m_mag   = tot_mag[TOT_W-1:FRAC_BITS];
        carry_new = {1'b0, tot_mag[FRAC_BITS-1:0]};
        if (tot[TOT_W-1]) begin
            carry_new = ~carry_new + 1'b1;
            if (m_mag > STEP_W'(32768)) begin
                move_new = 16'h8000;
            end else begin
                move_new = ~m_mag[MOVE_W-1:0] + 1'b1;
            end
        end else begin
            if (m_mag > STEP_W'(32767)) begin
                move_new = 16'h7FFF;
            end else begin
                move_new = m_mag[MOVE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_EDT;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            integ_x_reg  <= '0;
            integ_y_reg  <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            carry_x_reg  <= '0;
            carry_y_reg  <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        tgt_x_reg <= s_tdata[19:0];
                        tgt_y_reg <= s_tdata[39:20];
                        dt_reg    <= (dt_clamp == '0) ? STEP_W'(1) : dt_clamp;
                        if (s_tuser[0]) begin
                            integ_x_reg <= '0;
                            integ_y_reg <= '0;
                            last_x_reg  <= '0;
                            last_y_reg  <= '0;
                            carry_x_reg <= '0;
                            carry_y_reg <= '0;
                        end
                        axis_reg  <= 1'b0;
                        op_reg    <= OP_EDT;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    case (op_reg)
                        OP_EDT: begin
                            if (axis_reg) integ_y_reg <= isat;
                            else          integ_x_reg <= isat;
                            op_reg    <= OP_KP;
                            state_reg <= ST_MUL;
                        end
                        OP_KP: begin
                            drv_reg   <= pm;
                            op_reg    <= OP_KILO;
                            state_reg <= ST_MUL;
                        end
                        OP_KILO: begin
                            part_reg  <= prod;
                            op_reg    <= OP_KIHI;
                            state_reg <= ST_MUL;
                        end
                        OP_KIHI: begin
                            drv_reg   <= drv_reg + tm;
                            op_reg    <= OP_KD;
                            state_reg <= ST_MUL;
                        end
                        OP_KD: begin
                            kd_neg_reg <= cfg.kd[GAIN_W-1] ^ diff[DIFF_W-1];
                            if (axis_reg) last_y_reg <= e_cur;
                            else          last_x_reg <= e_cur;
                            state_reg  <= ST_DIV;
                        end
                        OP_SLO: begin
                            part_reg  <= prod;
                            op_reg    <= OP_SHI;
                            state_reg <= ST_MUL;
                        end
                        OP_SHI: begin
                            ma_reg     <= ma_cap;
                            ma_neg_reg <= drv_reg[DRV_W-1];
                            state_reg  <= ST_CARRY;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_DIV: begin
                    if (!div_busy) begin
                        drv_reg   <= drv_reg + qm;
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    md_reg    <= drv_reg[DRV_W-1] ? MAG_W'(~drv_reg + 1'b1)
                                                  : drv_reg[MAG_W-1:0];
                    op_reg    <= OP_SLO;
                    state_reg <= ST_MUL;
                end
                ST_CARRY: begin
                    if (axis_reg) begin
                        carry_y_reg <= carry_new;
                        move_y_reg  <= move_new;
                        state_reg   <= ST_OUT;
                    end else begin
                        carry_x_reg <= carry_new;
                        move_x_reg  <= move_new;
                        axis_reg    <= 1'b1;
                        op_reg      <= OP_EDT;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {move_y_reg, move_x_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[rtl/tpps_cfg.sv]
// Configuration register file for the PID pointer step core.
// Depends on tpps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpps_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [tpps_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tpps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tpps_pkg::cfg_t                       cfg
);
    import tpps_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center   <= COORD_W'(81920);
            cfg_reg.kp       <= GAIN_W'(65536);
            cfg_reg.ki       <= '0;
            cfg_reg.kd       <= '0;
            cfg_reg.min_step <= STEP_W'(16667);
            cfg_reg.scale    <= SCALE_W'(65536);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CENTER:   cfg_reg.center   <= cfg_wdata[COORD_W-1:0];
                REG_PROP:     cfg_reg.kp       <= cfg_wdata;
                REG_INTEG:    cfg_reg.ki       <= cfg_wdata;
                REG_DERIV:    cfg_reg.kd       <= cfg_wdata;
                REG_MIN_STEP: cfg_reg.min_step <= cfg_wdata[STEP_W-1:0];
                REG_SCALE:    cfg_reg.scale    <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/tpps_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
// Depends on tpps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpps_mul (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [tpps_pkg::MUL_W-1:0]  op_a,
    input  wire logic [tpps_pkg::MUL_W-1:0]  op_b,
    output logic      [tpps_pkg::PROD_W-1:0] prod
);
    import tpps_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

[rtl/tpps_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on tpps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpps_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [tpps_pkg::DIVD_W-1:0] dividend,
    input  wire logic [tpps_pkg::STEP_W-1:0] divisor,
    output logic                             busy,
    output logic      [tpps_pkg::DIVD_W-1:0] quotient
);
    import tpps_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] dsr_reg;
    logic [STEP_W:0]   shifted;
    logic [STEP_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_reg <= trial[STEP_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[STEP_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire
